// ----- rtl/jvsd_pkg.sv -----
// Shared types and constants for the jagged vector stream deserializer.
package jvsd_pkg;

    localparam logic [31:0] SIZE_FLAG_MASK = 32'h4000_0000;
    localparam logic [3:0]  VERSION_BYTES  = 4'd2;
    localparam logic [3:0]  WORD4_BYTES    = 4'd4;
    localparam logic [3:0]  WORD8_BYTES    = 4'd8;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SIZE    = 3'd1,
        PH_VERSION = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_ELEM    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_ELEM  = 2'd0,
        KIND_LIST  = 2'd1,
        KIND_ENTRY = 2'd2
    } t_kind;

    localparam int PEND_ELEM  = 0;
    localparam int PEND_LIST  = 1;
    localparam int PEND_ENTRY = 2;

endpackage

// ----- rtl/jagged_vector_stream_deserializer.sv -----
// Top level: byte-stream parser for entries of nested big-endian lists.
//
// Takes one stream byte per cycle and parses it against the current phase
// (size, version, list length, element). Each byte updates the parser state
// and drops its results (element, list close, entry close) into a three-slot
// result bank that drains one word per cycle while the master is ready.
// A new byte is taken whenever the bank is empty or its last word is being
// taken, so bytes that give at most one result run at one byte per cycle
// while the master is ready; a byte that gives more results holds the input
// until its last result is being taken. No clearing pass after reset.
module jagged_vector_stream_deserializer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,      // element_type
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,     // [7:0] data_byte
    input  logic         i_s_axis_tuser,     // [0] entry_start
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,     // [63:0] element_bits, [127:64] running_offset
    output logic [1:0]   o_m_axis_tuser,     // [1:0] result_kind
    output logic         o_m_axis_tlast      // last_of_run
);
    import jvsd_pkg::*;

    logic        r_element_type;
    t_phase      r_phase,        n_phase;
    logic [2:0]  r_byte_in_word, n_byte_in_word;
    logic [31:0] r_entry_end,    n_entry_end;
    logic [31:0] r_entry_pos,    n_entry_pos;
    logic [31:0] r_elements_left, n_elements_left;
    logic [63:0] r_assembly,     n_assembly;
    logic [63:0] r_inner_total,  n_inner_total;
    logic [63:0] r_outer_total,  n_outer_total;

    logic [2:0]  r_pend, n_pend, new_pend;
    logic [63:0] r_elem_bits, n_elem_bits;

    logic        s_accept, m_take, single;
    logic [3:0]  cnt;
    logic [3:0]  need;
    logic [31:0] len;
    logic        in_entry;

    assign m_take   = o_m_axis_tvalid && i_m_axis_tready;
    assign single   = (r_pend == 3'b001) || (r_pend == 3'b010) || (r_pend == 3'b100);
    assign o_s_axis_tready = (r_pend == 3'b000) || (m_take && single);
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // parser next state
    always_comb begin
        n_phase         = r_phase;
        n_byte_in_word  = r_byte_in_word;
        n_entry_end     = r_entry_end;
        n_entry_pos     = r_entry_pos;
        n_elements_left = r_elements_left;
        n_assembly      = r_assembly;
        n_inner_total   = r_inner_total;
        n_outer_total   = r_outer_total;
        n_elem_bits     = r_elem_bits;
        new_pend        = 3'b000;
        cnt             = 4'd0;
        len             = 32'd0;
        in_entry        = 1'b0;
        need            = r_element_type ? WORD8_BYTES : WORD4_BYTES;

        if (i_s_axis_tuser) begin
            n_phase         = PH_SIZE;
            n_byte_in_word  = 3'd0;
            n_assembly      = 64'd0;
            n_entry_pos     = 32'd0;
            n_entry_end     = 32'd0;
            n_elements_left = 32'd0;
        end

        if (n_phase != PH_IDLE) begin
            if (n_entry_pos != 32'hFFFF_FFFF) begin
                n_entry_pos = n_entry_pos + 32'd1;
            end
            n_assembly = {n_assembly[55:0], i_s_axis_tdata};
            cnt        = {1'b0, n_byte_in_word} + 4'd1;
            len        = n_assembly[31:0];
            in_entry   = !n_entry_end[31] && (n_entry_pos < n_entry_end);

            unique case (n_phase)
                PH_SIZE: begin
                    if (cnt >= WORD4_BYTES) begin
                        n_entry_end = (n_assembly[31:0] & ~SIZE_FLAG_MASK) + 32'd4;
                        cnt         = 4'd0;
                        n_assembly  = 64'd0;
                        n_phase     = PH_VERSION;
                    end
                end
                PH_VERSION: begin
                    if (cnt >= VERSION_BYTES) begin
                        cnt        = 4'd0;
                        n_assembly = 64'd0;
                        if (in_entry) begin
                            n_phase = PH_LENGTH;
                        end else begin
                            n_phase              = PH_IDLE;
                            new_pend[PEND_ENTRY] = 1'b1;
                        end
                    end
                end
                PH_LENGTH: begin
                    if (cnt >= WORD4_BYTES) begin
                        cnt           = 4'd0;
                        n_assembly    = 64'd0;
                        n_inner_total = r_inner_total + {{32{len[31]}}, len};
                        if ((len == 32'd0) || len[31]) begin
                            n_outer_total       = r_outer_total + 64'd1;
                            new_pend[PEND_LIST] = 1'b1;
                            if (in_entry) begin
                                n_phase = PH_LENGTH;
                            end else begin
                                n_phase              = PH_IDLE;
                                new_pend[PEND_ENTRY] = 1'b1;
                            end
                        end else begin
                            n_elements_left = len;
                            n_phase         = PH_ELEM;
                        end
                    end
                end
                PH_ELEM: begin
                    if (cnt >= need) begin
                        n_elem_bits = r_element_type ? n_assembly
                                                     : {32'd0, n_assembly[31:0]};
                        cnt                 = 4'd0;
                        n_assembly          = 64'd0;
                        new_pend[PEND_ELEM] = 1'b1;
                        n_elements_left     = n_elements_left - 32'd1;
                        if (n_elements_left == 32'd0) begin
                            n_outer_total       = r_outer_total + 64'd1;
                            new_pend[PEND_LIST] = 1'b1;
                            if (in_entry) begin
                                n_phase = PH_LENGTH;
                            end else begin
                                n_phase              = PH_IDLE;
                                new_pend[PEND_ENTRY] = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            n_byte_in_word = cnt[2:0];
        end
    end

    // result bank
    always_comb begin
        n_pend = r_pend;
        if (m_take) begin
            priority if (r_pend[PEND_ELEM]) begin
                n_pend[PEND_ELEM] = 1'b0;
            end else if (r_pend[PEND_LIST]) begin
                n_pend[PEND_LIST] = 1'b0;
            end else begin
                n_pend[PEND_ENTRY] = 1'b0;
            end
        end
        if (s_accept) begin
            n_pend = new_pend;
        end
    end

    // output select
    always_comb begin
        o_m_axis_tvalid = (r_pend != 3'b000);
        o_m_axis_tlast  = single;
        priority if (r_pend[PEND_ELEM]) begin
            o_m_axis_tuser = KIND_ELEM;
            o_m_axis_tdata = {64'd0, r_elem_bits};
        end else if (r_pend[PEND_LIST]) begin
            o_m_axis_tuser = KIND_LIST;
            o_m_axis_tdata = {r_inner_total, 64'd0};
        end else begin
            o_m_axis_tuser = KIND_ENTRY;
            o_m_axis_tdata = {r_outer_total, 64'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_type  <= 1'b0;
            r_phase         <= PH_IDLE;
            r_byte_in_word  <= 3'd0;
            r_entry_end     <= 32'd0;
            r_entry_pos     <= 32'd0;
            r_elements_left <= 32'd0;
            r_assembly      <= 64'd0;
            r_inner_total   <= 64'd0;
            r_outer_total   <= 64'd0;
            r_pend          <= 3'b000;
        end else begin
            if (i_cfg_wr_en) begin
                r_element_type <= i_cfg_wr_data;
            end
            r_pend <= n_pend;
            if (s_accept) begin
                r_phase         <= n_phase;
                r_byte_in_word  <= n_byte_in_word;
                r_entry_end     <= n_entry_end;
                r_entry_pos     <= n_entry_pos;
                r_elements_left <= n_elements_left;
                r_assembly      <= n_assembly;
                r_inner_total   <= n_inner_total;
                r_outer_total   <= n_outer_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_elem_bits <= n_elem_bits;
        end
    end

    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && !i_s_axis_tuser && (r_phase == PH_IDLE) |=> (r_pend == 3'b000))
        else $error("byte outside an entry produced a result");

    a_close_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && new_pend[PEND_ENTRY] |=> (r_phase == PH_IDLE))
        else $error("entry close without returning to idle");

    a_elem_in_elem_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && new_pend[PEND_ELEM] |-> (r_phase == PH_ELEM) && !i_s_axis_tuser)
        else $error("element result outside element phase");

    a_pos_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && !i_s_axis_tuser |=> (r_entry_pos >= $past(r_entry_pos)))
        else $error("entry position moved backward");

endmodule
